// File: design/pcc_pkg.sv
// package: widths, codes and helpers of the prefix code table codec
package pcc_pkg;

  localparam int MAX_LEN      = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int LEN_CAP      = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
  localparam int SYM_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W      = LEN_W + CODE_W;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  localparam logic [1:0] KIND_CODE     = 2'd0;
  localparam logic [1:0] KIND_SYMBOL   = 2'd1;
  localparam logic [1:0] KIND_NO_CODE  = 2'd2;
  localparam logic [1:0] KIND_OVERLONG = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } res_t;

  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W:0] t;
    t = (CODE_W+1)'(1) << len;
    return t[CODE_W-1:0] - CODE_W'(1);
  endfunction

  function automatic logic sym_in_table(input logic [SYM_W-1:0] s);
    return ({1'b0, s} < (SYM_W+1)'(SYMBOL_COUNT));
  endfunction

endpackage

// File: design/pcc_if.sv
// interfaces: input and result channels of the prefix code table codec
interface pcc_in_if;
  import pcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              in_bit;
  logic              stream_start;

  modport source (output valid, action, symbol, code_bits, code_length, in_bit,
                  stream_start, input ready);
  modport sink (input valid, action, symbol, code_bits, code_length, in_bit,
                stream_start, output ready);
endinterface

interface pcc_out_if;
  import pcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [SYM_W-1:0]  out_symbol;
  logic [CODE_W-1:0] out_code;
  logic [LEN_W-1:0]  out_length;

  modport source (output valid, result_kind, out_symbol, out_code, out_length,
                  input ready);
  modport sink (input valid, result_kind, out_symbol, out_code, out_length,
                output ready);
endinterface

// File: design/prefix_code_table_codec.sv
// top level: prefix code table with encode lookup and bitwise decode scan
// load: no result word; encode: result word registered via the ENC and EMIT states after accept
// decode: one table read per cycle over the entry memory, up to 256 entries;
//   a result only on a match or an overlong code, and the next word is taken only back in idle
// result register decouples the output side; a word is taken whenever the engine is idle
// reset clears the valid bits, the reader and the output; table memory is not cleared
module prefix_code_table_codec (
  input  logic            clk,
  input  logic            rst_n,
  pcc_in_if.sink          in_chan,
  pcc_out_if.source       out_chan
);
  import pcc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ENC, ST_SCAN, ST_EMIT} state_t;

  state_t                  state_r, state_nxt;
  logic [SYMBOL_COUNT-1:0] valid_r, valid_nxt;
  logic [CODE_W-1:0]       reader_bits_r, reader_bits_nxt;
  logic [LEN_W-1:0]        reader_count_r, reader_count_nxt;
  logic [SYM_AW-1:0]       idx_r, idx_nxt;
  logic [SYM_W-1:0]        sym_r, sym_nxt;
  res_t                    res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    out_res_r, out_res_nxt;

  logic [ENTRY_W-1:0]      mem [SYMBOL_COUNT];
  logic [ENTRY_W-1:0]      rd_data_r;
  logic [SYM_AW-1:0]       rd_addr;
  logic                    mem_we;
  logic [CODE_W-1:0]       rd_code;
  logic [LEN_W-1:0]        rd_len;
  logic                    in_acc;
  logic                    hit;
  logic [CODE_W-1:0]       base_bits;
  logic [LEN_W-1:0]        base_count;
  logic [SYM_AW-1:0]       in_idx;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign in_idx  = in_chan.symbol[SYM_AW-1:0];
  assign rd_code = rd_data_r[CODE_W-1:0];
  assign rd_len  = rd_data_r[ENTRY_W-1:CODE_W];
  assign hit     = valid_r[idx_r] && (rd_len == reader_count_r) && (rd_code == reader_bits_r);

  assign mem_we = in_acc && (in_chan.action == ACT_LOAD) && sym_in_table(in_chan.symbol) &&
                  (in_chan.code_length != '0) && (in_chan.code_length <= LEN_W'(LEN_CAP));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_idx] <= {in_chan.code_length, in_chan.code_bits & low_mask(in_chan.code_length)};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    reader_bits_nxt  = reader_bits_r;
    reader_count_nxt = reader_count_r;
    idx_nxt          = idx_r;
    sym_nxt          = sym_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_res_nxt      = out_res_r;
    rd_addr          = idx_r + SYM_AW'(1);
    base_bits        = in_chan.stream_start ? '0 : reader_bits_r;
    base_count       = in_chan.stream_start ? '0 : reader_count_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = (in_chan.action == ACT_ENCODE) ? in_idx : '0;
        if (in_acc) begin
          case (in_chan.action)
            ACT_LOAD: begin
              if (sym_in_table(in_chan.symbol)) begin
                if (in_chan.code_length == '0) begin
                  valid_nxt[in_idx] = 1'b0;
                end else if (in_chan.code_length <= LEN_W'(LEN_CAP)) begin
                  valid_nxt[in_idx] = 1'b1;
                end
              end
            end
            ACT_ENCODE: begin
              sym_nxt   = in_chan.symbol;
              state_nxt = ST_ENC;
            end
            ACT_DECODE: begin
              reader_bits_nxt  = {base_bits[CODE_W-2:0], in_chan.in_bit};
              reader_count_nxt = base_count + LEN_W'(1);
              idx_nxt          = '0;
              state_nxt        = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ENC: begin
        if (sym_in_table(sym_r) && valid_r[sym_r[SYM_AW-1:0]]) begin
          res_nxt = '{kind: KIND_CODE, symbol: sym_r, code: rd_code, length: rd_len};
        end else begin
          res_nxt = '{kind: KIND_NO_CODE, symbol: sym_r, code: '0, length: '0};
        end
        state_nxt = ST_EMIT;
      end
      ST_SCAN: begin
        if (hit) begin
          res_nxt = '{kind: KIND_SYMBOL, symbol: SYM_W'(idx_r), code: reader_bits_r,
                      length: reader_count_r};
          reader_bits_nxt  = '0;
          reader_count_nxt = '0;
          state_nxt        = ST_EMIT;
        end else if (idx_r == SYM_AW'(SYMBOL_COUNT - 1)) begin
          if (reader_count_r >= LEN_W'(LEN_CAP)) begin
            res_nxt = '{kind: KIND_OVERLONG, symbol: '0, code: reader_bits_r,
                        length: reader_count_r};
            reader_bits_nxt  = '0;
            reader_count_nxt = '0;
            state_nxt        = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + SYM_AW'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      valid_r        <= '0;
      reader_bits_r  <= '0;
      reader_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      valid_r        <= valid_nxt;
      reader_bits_r  <= reader_bits_nxt;
      reader_count_r <= reader_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    sym_r     <= sym_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_res_r.kind;
  assign out_chan.out_symbol  = out_res_r.symbol;
  assign out_chan.out_code    = out_res_r.code;
  assign out_chan.out_length  = out_res_r.length;

`ifndef SYNTHESIS
  a_reader_bound: assert property (@(posedge clk) disable iff (!rst_n)
    reader_count_r <= LEN_W'(LEN_CAP))
    else $error("reader count above limit");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("table write during decode scan");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result word raised outside emit");

  a_match_clears_reader: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && hit) |=> (reader_count_r == '0 && state_r == ST_EMIT))
    else $error("reader not cleared after match");
`endif

endmodule
